/* rtl/gbc_pkg.sv */
// gbc_pkg: shared types and constants of the gyro bias calibrate and correct block
// no dependencies; used by gbc_div and gyro_bias_calibrate_and_correct_top

package gbc_pkg;

    // number of samples averaged per calibration run (1 to 256)
    localparam int CAL_SAMPLES = 100;

    localparam int AXES    = 3;
    localparam int WORD_W  = 16;
    localparam int SUM_W   = 24;
    localparam int CNT_W   = 9;
    localparam int DATA_W  = 6 * WORD_W;
    localparam int USER_W  = 2;

    // result tuser bit positions
    localparam int USER_CALIBRATING = 0;
    localparam int USER_DONE        = 1;

    // input tuser command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_BEGIN  = 1'b1;

    // reciprocal for the sum / CAL_SAMPLES step: floor(n * m / 2^31) == floor(n / N)
    // holds for n < N * 2^15 because (N - 1) * n < 2^31
    localparam int DIV_SHIFT  = 31;
    localparam int MAGIC_W    = 32;
    localparam int PROD_W     = SUM_W + MAGIC_W;
    localparam logic [63:0] DIV_MAGIC_64 =
        ((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = DIV_MAGIC_64[MAGIC_W-1:0];

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [CNT_W-1:0]         t_count;

    typedef t_word [AXES-1:0] t_word_vec;
    typedef t_sum  [AXES-1:0] t_sum_vec;

    // status of the offset divider toward the datapath
    typedef struct packed {
        logic busy;
        logic valid;
    } t_div_status;

endpackage

/* rtl/gyro_bias_calibrate_and_correct_top.sv */
// gyro_bias_calibrate_and_correct_top: gyro offset correction with averaging calibration
// depends on gbc_pkg and gbc_div
//
// usage
//   s_axis carries one sensor read per transfer: tuser is the command (sample or
//   begin calibration), tdata the accel and gyro words. m_axis returns exactly one
//   result transfer per input transfer, in order: accel passed through, gyro with
//   the stored axis offset removed (-1 when the difference is not strictly inside the
//   int16 range), and the calibrating / calibration_done flags in tuser.
//   a begin command zeroes offsets, sums and count and answers with all-zero data
//   and calibrating set; the next CAL_SAMPLES samples are summed per axis and the
//   one that completes the run carries calibration_done.
// pipeline and throughput
//   input register, then result register; one transfer per cycle while m_axis
//   accepts and the divider is idle. after the completing sample the input stage
//   holds while the shared reciprocal divider turns the sums into new offsets.
// reset and stall
//   synchronous active-low reset empties both stages and clears offsets, sums,
//   count and collecting. when m_axis stalls the result register holds, the input
//   register still takes one more item, then s_axis_tready drops.

module gyro_bias_calibrate_and_correct_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
    input  logic [gbc_pkg::DATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [0:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
    output logic [gbc_pkg::DATA_W-1:0]  m_axis_tdata,
    // calibrating, calibration_done
    output logic [gbc_pkg::USER_W-1:0]  m_axis_tuser
);

    // input register
    logic                           r_in_valid;
    logic [gbc_pkg::DATA_W-1:0]     r_in_data;
    logic                           r_in_cmd;

    // result register
    logic                           r_out_valid;
    logic [gbc_pkg::DATA_W-1:0]     r_out_data;
    logic [gbc_pkg::USER_W-1:0]     r_out_user;
    logic [gbc_pkg::DATA_W-1:0]     n_out_data;
    logic [gbc_pkg::USER_W-1:0]     n_out_user;

    // calibration state
    gbc_pkg::t_word_vec             r_offsets;
    gbc_pkg::t_sum_vec              r_sums;
    gbc_pkg::t_count                r_samples_taken;
    logic                           r_collecting;
    logic                           r_div_req;
    gbc_pkg::t_sum_vec              n_sums;
    gbc_pkg::t_count                n_samples_taken;

    gbc_pkg::t_word_vec             w_gyro_corr;
    gbc_pkg::t_word_vec             w_div_quot;
    gbc_pkg::t_div_status           w_div_status;
    logic                           w_div_busy;
    logic                           w_advance;
    logic                           w_complete;
    logic                           w_is_begin;

    // divider busy covers the request cycle too, offsets are stale until load
    assign w_div_busy    = r_div_req | w_div_status.busy;
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready) && !w_div_busy;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_is_begin    = (r_in_cmd == gbc_pkg::CMD_BEGIN);

    // correction, accumulation and result formatting
    always_comb begin
        logic signed [gbc_pkg::WORD_W:0] diff;
        logic [gbc_pkg::WORD_W-1:0]      raw;
        for (int a = 0; a < gbc_pkg::AXES; a++) begin
            raw  = r_in_data[(3 + a) * gbc_pkg::WORD_W +: gbc_pkg::WORD_W];
            diff = $signed({raw[gbc_pkg::WORD_W-1], raw}) -
                   $signed({r_offsets[a][gbc_pkg::WORD_W-1], r_offsets[a]});
            // keep only differences strictly inside the int16 range
            if (diff > -17'sd32768 && diff < 17'sd32767) begin
                w_gyro_corr[a] = diff[gbc_pkg::WORD_W-1:0];
            end else begin
                w_gyro_corr[a] = '1;
            end
            n_sums[a] = r_sums[a] + {{(gbc_pkg::SUM_W - gbc_pkg::WORD_W)
                                       {w_gyro_corr[a][gbc_pkg::WORD_W-1]}}, w_gyro_corr[a]};
        end
        n_samples_taken = r_samples_taken + 1'b1;
        w_complete      = r_collecting &&
                          (n_samples_taken >= gbc_pkg::CNT_W'(gbc_pkg::CAL_SAMPLES));

        n_out_data = '0;
        n_out_user = '0;
        if (w_is_begin) begin
            n_out_user[gbc_pkg::USER_CALIBRATING] = 1'b1;
        end else begin
            n_out_data[0 +: 3 * gbc_pkg::WORD_W] = r_in_data[0 +: 3 * gbc_pkg::WORD_W];
            for (int a = 0; a < gbc_pkg::AXES; a++) begin
                n_out_data[(3 + a) * gbc_pkg::WORD_W +: gbc_pkg::WORD_W] = w_gyro_corr[a];
            end
            n_out_user[gbc_pkg::USER_CALIBRATING] = r_collecting && !w_complete;
            n_out_user[gbc_pkg::USER_DONE]        = w_complete;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_cmd  <= s_axis_tuser[0];
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    // calibration state: begin clears, samples accumulate, divider loads offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offsets       <= '0;
            r_sums          <= '0;
            r_samples_taken <= '0;
            r_collecting    <= 1'b0;
            r_div_req       <= 1'b0;
        end else begin
            r_div_req <= 1'b0;
            if (w_div_status.valid) begin
                r_offsets <= w_div_quot;
            end
            if (w_advance) begin
                if (w_is_begin) begin
                    r_offsets       <= '0;
                    r_sums          <= '0;
                    r_samples_taken <= '0;
                    r_collecting    <= 1'b1;
                end else if (r_collecting) begin
                    r_sums          <= n_sums;
                    r_samples_taken <= n_samples_taken;
                    if (w_complete) begin
                        r_collecting <= 1'b0;
                        r_div_req    <= 1'b1;
                    end
                end
            end
        end
    end

    gbc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_div_req),
        .i_sums   (r_sums),
        .o_status (w_div_status),
        .o_quot   (w_div_quot)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // no item moves through while the offsets are being recomputed
    a_no_advance_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> !w_advance)
        else $error("item advanced while offsets were being loaded");

    // offsets stay zero for the whole collection run
    a_offsets_zero_while_collecting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collecting |-> (r_offsets == '0))
        else $error("nonzero offset during collection");

    // count never reaches the run length while still collecting
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collecting |-> (r_samples_taken < gbc_pkg::CNT_W'(gbc_pkg::CAL_SAMPLES)))
        else $error("sample count ran past the calibration length");

    // offsets change only through a begin command or a divider load
    a_offsets_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_div_status.valid && !(w_advance && w_is_begin) |=> $stable(r_offsets))
        else $error("offsets changed without begin or divider load");

    // done and calibrating are never flagged together
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_user[gbc_pkg::USER_DONE] &&
                          r_out_user[gbc_pkg::USER_CALIBRATING]))
        else $error("done and calibrating both set");

endmodule

/* rtl/gbc_div.sv */
// gbc_div: divides the three axis sums by the calibration sample count
// depends on gbc_pkg; quotients valid after the magnitude and product registers

module gbc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  gbc_pkg::t_sum_vec   i_sums,
    output gbc_pkg::t_div_status o_status,
    output gbc_pkg::t_word_vec  o_quot
);

    logic                                   r_v1;
    logic                                   r_v2;
    logic [gbc_pkg::AXES-1:0]               r_neg;
    logic [gbc_pkg::AXES-1:0][gbc_pkg::SUM_W-1:0]  r_mag;
    logic [gbc_pkg::AXES-1:0][gbc_pkg::PROD_W-1:0] r_prod;
    logic [gbc_pkg::AXES-1:0][gbc_pkg::SUM_W-1:0]  n_mag;
    logic [gbc_pkg::AXES-1:0][gbc_pkg::PROD_W-1:0] n_prod;

    always_comb begin
        for (int a = 0; a < gbc_pkg::AXES; a++) begin
            // magnitude of the sum, sign kept apart for truncation toward zero
            n_mag[a]  = i_sums[a][gbc_pkg::SUM_W-1] ? (~i_sums[a] + 1'b1) : i_sums[a];
            n_prod[a] = {{gbc_pkg::MAGIC_W{1'b0}}, r_mag[a]} *
                        {{gbc_pkg::SUM_W{1'b0}}, gbc_pkg::DIV_MAGIC};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int a = 0; a < gbc_pkg::AXES; a++) begin
                r_neg[a] <= i_sums[a][gbc_pkg::SUM_W-1];
                r_mag[a] <= n_mag[a];
            end
        end
        if (r_v1) begin
            r_prod <= n_prod;
        end
    end

    always_comb begin
        for (int a = 0; a < gbc_pkg::AXES; a++) begin
            o_quot[a] = r_neg[a]
                ? ~r_prod[a][gbc_pkg::DIV_SHIFT +: gbc_pkg::WORD_W] + 1'b1
                : r_prod[a][gbc_pkg::DIV_SHIFT +: gbc_pkg::WORD_W];
        end
        o_status.busy  = r_v1 | r_v2;
        o_status.valid = r_v2;
    end

endmodule

/* test/tb_gyro_bias_calibrate_and_correct_top.sv */
// tb_gyro_bias_calibrate_and_correct_top: self-checking bench for the gyro bias block
// drives sensor reads and calibration commands, checks every result transfer
// depends on gbc_pkg and gyro_bias_calibrate_and_correct_top

`timescale 1ns / 1ps

module tb_gyro_bias_calibrate_and_correct_top;

    // cycles without any transfer on either side before the run is abandoned
    localparam int IDLE_LIMIT    = 2000;
    // long receiver hold-off, long enough to fill both stages and stall s_axis
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 200;
    // settle time after the last result: result path plus divider turnaround
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_TARGET = 640;

    // one sensor read as it travels on s_axis
    typedef struct packed {
        logic               cmd;
        gbc_pkg::t_word_vec gyro;
        gbc_pkg::t_word_vec accel;
    } t_sensor_read;

    // one result as it travels on m_axis
    typedef struct packed {
        logic               done;
        logic               calibrating;
        gbc_pkg::t_word_vec gyro;
        gbc_pkg::t_word_vec accel;
    } t_corrected;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
    logic [gbc_pkg::DATA_W-1:0]  s_axis_tdata = '0;
    // command
    logic [0:0]                  s_axis_tuser = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
    logic [gbc_pkg::DATA_W-1:0]  m_axis_tdata;
    // calibrating, calibration_done
    logic [gbc_pkg::USER_W-1:0]  m_axis_tuser;

    gyro_bias_calibrate_and_correct_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // reads waiting to be offered, corrected results waiting to come back
    t_sensor_read reads_to_send[$];
    t_corrected   corrected_due[$];

    int mismatch_count = 0;
    int results_seen   = 0;

    // ------------------------------------------------------------------
    // bias model: offsets, running sums, sample count, collecting flag
    // ------------------------------------------------------------------
    int gyro_offset[gbc_pkg::AXES];
    int gyro_sum[gbc_pkg::AXES];
    int cal_count;
    bit cal_active;

    initial begin
        for (int a = 0; a < gbc_pkg::AXES; a++) begin
            gyro_offset[a] = 0;
            gyro_sum[a]    = 0;
        end
        cal_count  = 0;
        cal_active = 1'b0;
    end

    // expected result of one accepted read; advances the bias model
    function automatic t_corrected correct_gyro_read(t_sensor_read rd);
        t_corrected res;
        int         diff;
        res = '0;
        // begin command: clear everything, answer with zero data
        if (rd.cmd == gbc_pkg::CMD_BEGIN) begin
            for (int a = 0; a < gbc_pkg::AXES; a++) begin
                gyro_offset[a] = 0;
                gyro_sum[a]    = 0;
            end
            cal_count       = 0;
            cal_active      = 1'b1;
            res.calibrating = 1'b1;
            return res;
        end
        // offset removal, differences not strictly inside the int16 range flagged as -1
        for (int a = 0; a < gbc_pkg::AXES; a++) begin
            diff = int'($signed(rd.gyro[a])) - gyro_offset[a];
            res.gyro[a] = (diff > -32768 && diff < 32767) ? gbc_pkg::t_word'(diff)
                                                          : gbc_pkg::t_word'(-1);
        end
        if (cal_active) begin
            for (int a = 0; a < gbc_pkg::AXES; a++)
                gyro_sum[a] += int'($signed(res.gyro[a]));
            cal_count++;
            // completing sample: load averages, truncated toward zero
            if (cal_count >= gbc_pkg::CAL_SAMPLES) begin
                for (int a = 0; a < gbc_pkg::AXES; a++)
                    gyro_offset[a] = gyro_sum[a] / gbc_pkg::CAL_SAMPLES;
                cal_active = 1'b0;
                res.done   = 1'b1;
            end
        end
        res.accel       = rd.accel;
        res.calibrating = cal_active;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic gbc_pkg::t_word any_word();
        return gbc_pkg::t_word'($urandom);
    endfunction

    // value around a center, clamped to the 16-bit range
    function automatic gbc_pkg::t_word near_word(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return gbc_pkg::t_word'(v);
    endfunction

    // full-range gyro word with the corner values showing up often
    function automatic gbc_pkg::t_word gyro_word();
        case ($urandom_range(0, 11))
            0:       return gbc_pkg::t_word'(32767);
            1:       return gbc_pkg::t_word'(-32768);
            2:       return gbc_pkg::t_word'(-1);
            3:       return gbc_pkg::t_word'(0);
            default: return any_word();
        endcase
    endfunction

    task automatic queue_read(logic cmd, int ax, int ay, int az, int gx, int gy, int gz);
        t_sensor_read rd;
        rd.cmd      = cmd;
        rd.accel[0] = gbc_pkg::t_word'(ax);
        rd.accel[1] = gbc_pkg::t_word'(ay);
        rd.accel[2] = gbc_pkg::t_word'(az);
        rd.gyro[0]  = gbc_pkg::t_word'(gx);
        rd.gyro[1]  = gbc_pkg::t_word'(gy);
        rd.gyro[2]  = gbc_pkg::t_word'(gz);
        reads_to_send.push_back(rd);
    endtask

    // plain samples with random content, no command
    task automatic queue_free_samples(int count);
        t_sensor_read rd;
        for (int n = 0; n < count; n++) begin
            rd.cmd = gbc_pkg::CMD_SAMPLE;
            for (int a = 0; a < gbc_pkg::AXES; a++) begin
                rd.accel[a] = any_word();
                rd.gyro[a]  = gyro_word();
            end
            reads_to_send.push_back(rd);
        end
    endtask

    // begin command followed by biased samples; a short count leaves the run open
    task automatic queue_calibration_run(int count);
        t_sensor_read rd;
        int           center[gbc_pkg::AXES];
        int           spread[gbc_pkg::AXES];
        for (int a = 0; a < gbc_pkg::AXES; a++) begin
            case ($urandom_range(0, 3))
                0: begin
                    center[a] = int'($urandom_range(0, 600)) - 300;
                    spread[a] = 40;
                end
                1: begin
                    center[a] = int'($urandom_range(32700, 32766));
                    spread[a] = 60;
                end
                2: begin
                    center[a] = -int'($urandom_range(32700, 32767));
                    spread[a] = 60;
                end
                default: begin
                    center[a] = 0;
                    spread[a] = 32768;
                end
            endcase
        end
        // data of the begin command is ignored by the block, so make it busy
        rd.cmd = gbc_pkg::CMD_BEGIN;
        for (int a = 0; a < gbc_pkg::AXES; a++) begin
            rd.accel[a] = any_word();
            rd.gyro[a]  = any_word();
        end
        reads_to_send.push_back(rd);
        rd.cmd = gbc_pkg::CMD_SAMPLE;
        for (int n = 0; n < count; n++) begin
            for (int a = 0; a < gbc_pkg::AXES; a++) begin
                rd.accel[a] = any_word();
                rd.gyro[a]  = near_word(center[a], spread[a]);
            end
            reads_to_send.push_back(rd);
        end
    endtask

    // ------------------------------------------------------------------
    // sender: offers queued reads, random gaps between transfers
    // ------------------------------------------------------------------
    t_sensor_read on_bus;
    int           send_gap = 0;
    bit           send_steady = 1'b0;

    function automatic int pick_send_gap();
        int r;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        if (send_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    always @(posedge i_clk) begin : send_proc
        logic nxt_valid;
        nxt_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            // accepted transfer: predict its result right away
            if (s_axis_tvalid && s_axis_tready) begin
                corrected_due.push_back(correct_gyro_read(on_bus));
                nxt_valid = 1'b0;
                send_gap  = pick_send_gap();
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (reads_to_send.size() > 0) begin
                    on_bus        = reads_to_send.pop_front();
                    s_axis_tdata <= {on_bus.gyro, on_bus.accel};
                    s_axis_tuser <= on_bus.cmd;
                    nxt_valid     = 1'b1;
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
    end

    // ------------------------------------------------------------------
    // receiver: checks each result against the oldest prediction
    // ------------------------------------------------------------------
    int hold_left  = 0;
    int stall_left = 0;
    bit hold_done  = 1'b0;
    bit recv_steady = 1'b0;

    always @(posedge i_clk) begin : recv_proc
        logic       nxt_ready;
        t_corrected got;
        t_corrected want;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.accel       = m_axis_tdata[3*gbc_pkg::WORD_W-1:0];
                got.gyro        = m_axis_tdata[gbc_pkg::DATA_W-1:3*gbc_pkg::WORD_W];
                got.calibrating = m_axis_tuser[gbc_pkg::USER_CALIBRATING];
                got.done        = m_axis_tuser[gbc_pkg::USER_DONE];
                if (corrected_due.size() == 0) begin
                    $display("%0t: unexpected result transfer, got %h", $realtime, got);
                    mismatch_count++;
                end else begin
                    want = corrected_due.pop_front();
                    for (int a = 0; a < gbc_pkg::AXES; a++) begin
                        if (got.accel[a] !== want.accel[a]) begin
                            $display("%0t: accel[%0d] expected %0d got %0d", $realtime, a,
                                     $signed(want.accel[a]), $signed(got.accel[a]));
                            mismatch_count++;
                        end
                        if (got.gyro[a] !== want.gyro[a]) begin
                            $display("%0t: gyro[%0d] expected %0d got %0d", $realtime, a,
                                     $signed(want.gyro[a]), $signed(got.gyro[a]));
                            mismatch_count++;
                        end
                    end
                    if (got.calibrating !== want.calibrating) begin
                        $display("%0t: calibrating expected %b got %b", $realtime,
                                 want.calibrating, got.calibrating);
                        mismatch_count++;
                    end
                    if (got.done !== want.done) begin
                        $display("%0t: calibration_done expected %b got %b", $realtime,
                                 want.done, got.done);
                        mismatch_count++;
                    end
                end
                results_seen++;
                // one long hold-off so the block backs up into s_axis
                if (results_seen == HOLD_AFTER && !hold_done) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (stall_left > 0) begin
                stall_left--;
            end else begin
                nxt_ready = 1'b1;
                if ($urandom_range(0, 49) == 0)
                    recv_steady = !recv_steady;
                if (!recv_steady && $urandom_range(0, 5) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                              : $urandom_range(1, 3);
            end
        end
        m_axis_tready <= nxt_ready;
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transfer means the block is stuck
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("gyro_bias_calibrate_and_correct_top: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        // sample straight after reset: zero offsets, range edges on every field
        queue_read(gbc_pkg::CMD_SAMPLE, 32767, -32768, 0, 32767, -32768, 0);
        queue_read(gbc_pkg::CMD_SAMPLE, -1, 1, 21845, 32766, -32767, -1);
        queue_read(gbc_pkg::CMD_SAMPLE, -21846, 0, -32768, -32767, 32766, 1);
        // begin with nonzero data, the data must not show up in the result
        queue_read(gbc_pkg::CMD_BEGIN, 32767, -1, -32768, 32767, -32768, -1);
        queue_read(gbc_pkg::CMD_SAMPLE, 100, 200, 300, 10, -20, 30);
        queue_read(gbc_pkg::CMD_SAMPLE, -100, -200, -300, 12, -18, 28);
        // begin while collecting restarts the count
        queue_read(gbc_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0);
        queue_read(gbc_pkg::CMD_SAMPLE, 1, 2, 3, 32767, -32768, 32766);
        queue_read(gbc_pkg::CMD_SAMPLE, 4, 5, 6, -32767, 0, -1);
        queue_read(gbc_pkg::CMD_BEGIN, -1, -1, -1, -1, -1, -1);

        // random part: mostly complete calibration runs, some aborted, some noise
        while (reads_to_send.size() < RANDOM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    queue_calibration_run(gbc_pkg::CAL_SAMPLES);
                    queue_free_samples($urandom_range(3, 25));
                end
                6, 7:    queue_calibration_run($urandom_range(0, gbc_pkg::CAL_SAMPLES - 1));
                default: queue_free_samples($urandom_range(1, 20));
            endcase
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything offered, accepted and answered
        while (reads_to_send.size() != 0 || s_axis_tvalid || corrected_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && corrected_due.size() == 0)
            $display("gyro_bias_calibrate_and_correct_top: match");
        else
            $display("gyro_bias_calibrate_and_correct_top: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/gbc_pkg.sv
rtl/gbc_div.sv
rtl/gyro_bias_calibrate_and_correct_top.sv
test/tb_gyro_bias_calibrate_and_correct_top.sv
